// File: rtl/irds_pkg.sv
// Shared types, register indexes and constants for the IR docking steering block.
// Used by irds_mode_sel, irds_cmd and ir_docking_steer_fsm; depends on nothing.
package irds_pkg;

   // Receiver byte mask and fixed speed and turn reductions once close-in has been entered.
   localparam logic [7:0] IR_MASK        = 8'h0d;
   localparam logic [6:0] CUT_FAR_SPEED  = 7'd50;
   localparam logic [6:0] CUT_NEAR_SPEED = 7'd20;
   localparam logic [6:0] CUT_TURN       = 7'd100;

   // Configuration register indexes.
   localparam logic [2:0] CSR_CLOSE_THRESH = 3'd0;
   localparam logic [2:0] CSR_NEAR_SPEED   = 3'd1;
   localparam logic [2:0] CSR_FAR_SPEED    = 3'd2;
   localparam logic [2:0] CSR_NEAR_TURN    = 3'd3;
   localparam logic [2:0] CSR_FAR_TURN     = 3'd4;
   localparam logic [2:0] CSR_SEARCH_SPEED = 3'd5;
   localparam logic [2:0] CSR_SEARCH_TURN  = 3'd6;

   // Output mode codes.
   localparam logic [2:0] CODE_INIT       = 3'd0;
   localparam logic [2:0] CODE_LEFT_NEAR  = 3'd1;
   localparam logic [2:0] CODE_LEFT_FAR   = 3'd2;
   localparam logic [2:0] CODE_RIGHT_NEAR = 3'd3;
   localparam logic [2:0] CODE_RIGHT_FAR  = 3'd4;
   localparam logic [2:0] CODE_CENTRED    = 3'd5;
   localparam logic [2:0] CODE_SEARCH     = 3'd6;
   localparam logic [2:0] CODE_CLOSE      = 3'd7;

   // Steering mode, held one-hot.
   typedef enum logic [7:0] {
      MODE_INIT       = 8'b0000_0001,
      MODE_LEFT_NEAR  = 8'b0000_0010,
      MODE_LEFT_FAR   = 8'b0000_0100,
      MODE_RIGHT_NEAR = 8'b0000_1000,
      MODE_RIGHT_FAR  = 8'b0001_0000,
      MODE_CENTRED    = 8'b0010_0000,
      MODE_SEARCH     = 8'b0100_0000,
      MODE_CLOSE      = 8'b1000_0000
   } mode_type;

   // Steering state carried from one request to the next.
   typedef struct packed {
      mode_type   mode;
      logic [7:0] count;
      logic       latched;
   } steer_state_type;

   // Configuration register set.
   typedef struct packed {
      logic [7:0]  close_thresh;
      logic [9:0]  near_speed;
      logic [9:0]  far_speed;
      logic [10:0] near_turn;
      logic [10:0] far_turn;
      logic [9:0]  search_speed;
      logic [10:0] search_turn;
   } cfg_type;

   // Register values after reset.
   localparam cfg_type CFG_RESET = '{
      close_thresh: 8'd100,
      near_speed:   10'd50,
      far_speed:    10'd100,
      near_turn:    11'd200,
      far_turn:     11'd250,
      search_speed: 10'd100,
      search_turn:  11'd700
   };

   // Encode the one-hot mode as the 3-bit output code.
   function automatic logic [2:0] mode_code(input mode_type mode);
      logic [2:0] code;
      unique case (mode)
         MODE_LEFT_NEAR:  code = CODE_LEFT_NEAR;
         MODE_LEFT_FAR:   code = CODE_LEFT_FAR;
         MODE_RIGHT_NEAR: code = CODE_RIGHT_NEAR;
         MODE_RIGHT_FAR:  code = CODE_RIGHT_FAR;
         MODE_CENTRED:    code = CODE_CENTRED;
         MODE_SEARCH:     code = CODE_SEARCH;
         MODE_CLOSE:      code = CODE_CLOSE;
         default:         code = CODE_INIT;
      endcase
      return code;
   endfunction

endpackage

// File: rtl/irds_mode_sel.sv
// Priority rule chain: picks the next steering mode, centred count and close latch.
// Depends on irds_pkg.
module irds_mode_sel (
   input  logic [7:0]                right_code,
   input  logic [7:0]                left_code,
   input  logic [7:0]                close_thresh,
   input  irds_pkg::steer_state_type state_cur,
   output irds_pkg::steer_state_type state_nxt
);

   logic [7:0] r;
   logic [7:0] l;

   assign r = right_code & irds_pkg::IR_MASK;
   assign l = left_code & irds_pkg::IR_MASK;

   // The first rule that holds wins; with no match the previous mode stays.
   always_comb begin
      state_nxt = state_cur;
      priority if (l == 8'd4 && (r == 8'd5 || r == 8'd4)) begin
         state_nxt.mode = irds_pkg::MODE_LEFT_NEAR;
      end else if (l == 8'd0 && r != 8'd0) begin
         state_nxt.mode = irds_pkg::MODE_LEFT_FAR;
      end else if (r == 8'd1 && (l == 8'd5 || l == 8'd1)) begin
         state_nxt.mode = irds_pkg::MODE_RIGHT_NEAR;
      end else if (r == 8'd0 && l != 8'd0) begin
         state_nxt.mode = irds_pkg::MODE_RIGHT_FAR;
      end else if (r == 8'd1 && l == 8'd4) begin
         state_nxt.mode = irds_pkg::MODE_CENTRED;
         if (state_cur.count != 8'hff) begin
            state_nxt.count = state_cur.count + 8'd1;
         end
      end else if (r == 8'd0 && l == 8'd0) begin
         state_nxt.mode = irds_pkg::MODE_SEARCH;
      end else if (state_cur.count >= close_thresh) begin
         state_nxt.mode = irds_pkg::MODE_CLOSE;
      end

      // Speed reductions stay on for good once close-in is reached.
      state_nxt.latched = state_cur.latched || (state_nxt.mode == irds_pkg::MODE_CLOSE);
   end

endmodule

// File: rtl/irds_cmd.sv
// Velocity command for a given mode, including the latched close-in reductions.
// Depends on irds_pkg.
module irds_cmd (
   input  irds_pkg::mode_type mode,
   input  logic               latched,
   input  irds_pkg::cfg_type  cfg,
   output logic [9:0]         linear_speed,
   output logic [11:0]        angular_rate
);

   logic [6:0]  dv;
   logic [6:0]  dv1;
   logic [6:0]  dw;
   logic [11:0] vx;

   assign dv  = latched ? irds_pkg::CUT_FAR_SPEED  : 7'd0;
   assign dv1 = latched ? irds_pkg::CUT_NEAR_SPEED : 7'd0;
   assign dw  = latched ? irds_pkg::CUT_TURN       : 7'd0;

   // Speed and turn per mode; both are formed in 12-bit two's complement.
   always_comb begin
      unique case (mode)
         irds_pkg::MODE_LEFT_NEAR: begin
            vx           = {2'b00, cfg.near_speed} - {5'b0, dv1};
            angular_rate = {5'b0, dw} - {1'b0, cfg.near_turn};
         end
         irds_pkg::MODE_LEFT_FAR: begin
            vx           = {2'b00, cfg.far_speed} - {5'b0, dv};
            angular_rate = {5'b0, dw} - {1'b0, cfg.far_turn};
         end
         irds_pkg::MODE_RIGHT_NEAR: begin
            vx           = {2'b00, cfg.near_speed} - {5'b0, dv1};
            angular_rate = {1'b0, cfg.near_turn} - {5'b0, dw};
         end
         irds_pkg::MODE_RIGHT_FAR: begin
            vx           = {2'b00, cfg.far_speed} - {5'b0, dv};
            angular_rate = {1'b0, cfg.far_turn} - {5'b0, dw};
         end
         irds_pkg::MODE_CENTRED: begin
            vx           = {2'b00, cfg.far_speed} - {5'b0, dv};
            angular_rate = 12'd0;
         end
         irds_pkg::MODE_SEARCH: begin
            vx           = {2'b00, cfg.search_speed};
            angular_rate = {1'b0, cfg.search_turn};
         end
         irds_pkg::MODE_CLOSE: begin
            vx           = {2'b00, cfg.far_speed} - {5'b0, irds_pkg::CUT_FAR_SPEED};
            angular_rate = 12'd0;
         end
         default: begin
            vx           = 12'd0;
            angular_rate = 12'd0;
         end
      endcase
   end

   // Negative forward speed is clamped at zero.
   assign linear_speed = vx[11] ? 10'd0 : vx[9:0];

endmodule

// File: rtl/ir_docking_steer_fsm.sv
// Top level of the IR docking steering block: request register, rule chain,
// command logic and result register. Depends on irds_pkg, irds_mode_sel and irds_cmd.
//
// Every request yields exactly one response, which passes through the input register and
// then the response register before it is presented on the response port; it stays there
// while the response port holds off. A new request can be accepted in every cycle unless
// the response register is full and the response port holds off: the path is an input
// register followed by the mode rules and command logic, which update the steering
// state and load the response register together. The centre receiver byte is
// carried on the bus but takes no part in steering. Configuration writes take effect
// on the next request and should be made while no request is in flight.
module ir_docking_steer_fsm (
   input  logic        clock,
   input  logic        reset,
   // Request: [7:0] right_code, [15:8] centre_code, [23:16] left_code
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // Response: [9:0] linear_speed, [21:10] angular_rate, [24:22] mode, [31:25] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   // Configuration write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   logic                      s1_valid_ff;
   logic [7:0]                right_ff;
   logic [7:0]                left_ff;
   logic                      rsp_valid_ff;
   logic [31:0]               rsp_data_ff;
   logic [31:0]               rsp_data_in;
   irds_pkg::steer_state_type state_ff;
   irds_pkg::steer_state_type state_in;
   irds_pkg::cfg_type         cfg_ff;
   logic                      advance;
   logic                      s1_fire;
   logic                      req_fire;
   logic [9:0]                linear_speed;
   logic [11:0]               angular_rate;

   // The pipeline moves whenever the response slot is free or being taken.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign s1_fire    = s1_valid_ff && advance;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= irds_pkg::CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            irds_pkg::CSR_CLOSE_THRESH: cfg_ff.close_thresh <= csr_wdata[7:0];
            irds_pkg::CSR_NEAR_SPEED:   cfg_ff.near_speed   <= csr_wdata[9:0];
            irds_pkg::CSR_FAR_SPEED:    cfg_ff.far_speed    <= csr_wdata[9:0];
            irds_pkg::CSR_NEAR_TURN:    cfg_ff.near_turn    <= csr_wdata;
            irds_pkg::CSR_FAR_TURN:     cfg_ff.far_turn     <= csr_wdata;
            irds_pkg::CSR_SEARCH_SPEED: cfg_ff.search_speed <= csr_wdata[9:0];
            irds_pkg::CSR_SEARCH_TURN:  cfg_ff.search_turn  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register holds the right and left receiver bytes.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         right_ff <= req_tdata[7:0];
         left_ff  <= req_tdata[23:16];
      end
   end

   // Rule chain and command for the request in the input register.
   irds_mode_sel u_mode_sel (
      .right_code   (right_ff),
      .left_code    (left_ff),
      .close_thresh (cfg_ff.close_thresh),
      .state_cur    (state_ff),
      .state_nxt    (state_in)
   );

   irds_cmd u_cmd (
      .mode         (state_in.mode),
      .latched      (state_in.latched),
      .cfg          (cfg_ff),
      .linear_speed (linear_speed),
      .angular_rate (angular_rate)
   );

   // Steering state advances once per request.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode    <= irds_pkg::MODE_INIT;
         state_ff.count   <= 8'd0;
         state_ff.latched <= 1'b0;
      end else if (s1_fire) begin
         state_ff <= state_in;
      end
   end

   // Response register.
   assign rsp_data_in = {7'b0, irds_pkg::mode_code(state_in.mode), angular_rate, linear_speed};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
